// ----- rtl/pressure_sensor_spi_slave_model_assert.svh -----
// Assertion macros for the barometric sensor SPI slave model.
`ifndef PRESSURE_SENSOR_SPI_SLAVE_MODEL_ASSERT_SVH
`define PRESSURE_SENSOR_SPI_SLAVE_MODEL_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked while reset is applied.
`define PSM_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/psm_pkg.sv -----
package psm_pkg;

    // Command codes and command groups (upper nibble)
    localparam logic [7:0] CMD_RESET   = 8'h1E;
    localparam logic [7:0] CMD_ADC     = 8'h00;
    localparam logic [3:0] CMD_PROM_HI = 4'hA;
    localparam logic [3:0] CMD_CONV_P  = 4'h4;
    localparam logic [3:0] CMD_CONV_T  = 4'h5;

    // PROM word numbers with special meaning
    localparam logic [2:0] PROM_WORD_ZERO = 3'd0;
    localparam logic [2:0] PROM_WORD_CRC  = 3'd7;

    // Configuration register indexes
    localparam logic [2:0] REG_PRESSURE_BASE    = 3'd6;
    localparam logic [2:0] REG_TEMPERATURE_BASE = 3'd7;

    // CRC4 polynomial used over the PROM contents
    localparam logic [15:0] CRC_POLY = 16'h3000;

    // Reset values: PROM words 6 down to 1, then the raw value bases
    localparam logic [5:0][15:0] PROM_RESET = {16'd28312, 16'd33464, 16'd23282,
                                               16'd23317, 16'd36924, 16'd40127};
    localparam logic [23:0] PRESSURE_BASE_RESET    = 24'd9085466;
    localparam logic [23:0] TEMPERATURE_BASE_RESET = 24'd8569150;

    // Configuration view handed from the register file to the core
    typedef struct packed {
        logic [5:0][15:0] prom;
        logic [23:0]      pressure_base;
        logic [23:0]      temperature_base;
        logic [3:0]       crc;
    } t_cfg;

endpackage

// ----- rtl/psm_cfg.sv -----
module psm_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_wr_data,
    output psm_pkg::t_cfg      o_cfg
);

    // CRC4 of a PROM image whose only set bit is bit j of word k. The CRC is
    // linear with a zero start, so the full CRC is the XOR of these terms.
    function automatic logic [3:0] crc_unit(input int k, input int j);
        logic [15:0] rem;
        int          byte_idx;
        int          i;
        int          b;
        begin
            rem = '0;
            byte_idx = 2 * k + ((j < 8) ? 1 : 0);
            for (i = 0; i < 16; i++) begin
                if (i == byte_idx) begin
                    rem = rem ^ (16'd1 << (j & 7));
                end
                for (b = 0; b < 8; b++) begin
                    rem = rem[15] ? ((rem << 1) ^ psm_pkg::CRC_POLY) : (rem << 1);
                end
            end
            return rem[15:12];
        end
    endfunction

    logic [5:0][15:0] r_prom;
    logic [23:0]      r_pressure_base;
    logic [23:0]      r_temperature_base;
    logic [3:0]       w_term [96];
    logic [3:0]       w_crc;

    // Register file writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prom             <= psm_pkg::PROM_RESET;
            r_pressure_base    <= psm_pkg::PRESSURE_BASE_RESET;
            r_temperature_base <= psm_pkg::TEMPERATURE_BASE_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                psm_pkg::REG_PRESSURE_BASE:    r_pressure_base    <= i_cfg_wr_data;
                psm_pkg::REG_TEMPERATURE_BASE: r_temperature_base <= i_cfg_wr_data;
                default:                       r_prom[i_cfg_index] <= i_cfg_wr_data[15:0];
            endcase
        end
    end

    // Each stored bit selects its constant contribution to the CRC.
    for (genvar gk = 0; gk < 6; gk++) begin : g_word
        for (genvar gj = 0; gj < 16; gj++) begin : g_bit
            localparam logic [3:0] MASK = crc_unit(gk + 1, gj);
            assign w_term[gk * 16 + gj] = r_prom[gk][gj] ? MASK : 4'd0;
        end
    end

    // XOR of all contributions gives the CRC nibble.
    always_comb begin
        w_crc = '0;
        for (int i = 0; i < 96; i++) begin
            w_crc = w_crc ^ w_term[i];
        end
    end

    assign o_cfg.prom             = r_prom;
    assign o_cfg.pressure_base    = r_pressure_base;
    assign o_cfg.temperature_base = r_temperature_base;
    assign o_cfg.crc              = w_crc;

endmodule

// ----- rtl/psm_core.sv -----
module psm_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_action,
    input  logic [7:0]    i_mosi_byte,
    input  logic          i_cs_level,
    output logic          o_in_stall,
    input  psm_pkg::t_cfg i_cfg,
    input  logic          i_out_full,
    output logic          o_push,
    output logic [7:0]    o_push_data
);

    // Input register
    logic        r_in_valid;
    logic        r_action;
    logic [7:0]  r_mosi_byte;
    logic        r_cs_level;

    // Sensor state
    logic [7:0]  r_reply [3];
    logic [1:0]  r_len;
    logic [1:0]  r_pos;
    logic [23:0] r_pressure_raw;
    logic [23:0] r_temperature_raw;
    logic        r_temp_sel;
    logic [5:0]  r_count;

    logic [7:0]  n_reply [3];
    logic [1:0]  n_len;
    logic [1:0]  n_pos;
    logic [23:0] n_pressure_raw;
    logic [23:0] n_temperature_raw;
    logic        n_temp_sel;
    logic [5:0]  n_count;
    logic        n_in_valid;

    logic        w_advance;
    logic        w_load;
    logic [1:0]  w_pos_inc;
    logic [5:0]  w_count_inc;
    logic [2:0]  w_word_num;
    logic [15:0] w_prom_word;
    logic [23:0] w_adc_value;
    logic [7:0]  w_queued;

    // A held item moves on when it needs no result or the output has room.
    assign w_advance  = r_in_valid && (r_action || !i_out_full);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_load     = i_in_valid && !o_in_stall;
    assign n_in_valid = w_load || (r_in_valid && !w_advance);

    assign w_pos_inc   = r_pos + 2'd1;
    assign w_count_inc = r_count + 6'd1;
    assign w_word_num  = r_mosi_byte[3:1];
    assign w_adc_value = r_temp_sel ? r_temperature_raw : r_pressure_raw;

    // PROM word lookup
    always_comb begin
        case (w_word_num)
            psm_pkg::PROM_WORD_ZERO: w_prom_word = '0;
            psm_pkg::PROM_WORD_CRC:  w_prom_word = {12'd0, i_cfg.crc};
            default:                 w_prom_word = i_cfg.prom[3'(w_word_num - 3'd1)];
        endcase
    end

    // Next queued reply byte
    always_comb begin
        case (r_pos)
            2'd0:    w_queued = r_reply[0];
            2'd1:    w_queued = r_reply[1];
            default: w_queued = r_reply[2];
        endcase
    end

    // Item processing
    always_comb begin
        n_reply           = r_reply;
        n_len             = r_len;
        n_pos             = r_pos;
        n_pressure_raw    = r_pressure_raw;
        n_temperature_raw = r_temperature_raw;
        n_temp_sel        = r_temp_sel;
        n_count           = r_count;
        o_push            = 1'b0;
        o_push_data       = '0;
        if (w_advance) begin
            if (r_action) begin
                if (r_cs_level) begin
                    n_len = '0;
                    n_pos = '0;
                end
            end else begin
                o_push = 1'b1;
                if (r_len != 2'd0) begin
                    // Queued reply takes priority over the command byte.
                    o_push_data = w_queued;
                    if (w_pos_inc >= r_len) begin
                        n_pos = '0;
                        n_len = '0;
                    end else begin
                        n_pos = w_pos_inc;
                    end
                end else if (r_mosi_byte == psm_pkg::CMD_RESET) begin
                    n_len             = '0;
                    n_pos             = '0;
                    n_pressure_raw    = i_cfg.pressure_base;
                    n_temperature_raw = i_cfg.temperature_base;
                    n_temp_sel        = 1'b0;
                    n_count           = '0;
                end else if (r_mosi_byte[7:4] == psm_pkg::CMD_PROM_HI && !r_mosi_byte[0]) begin
                    n_reply[0] = w_prom_word[15:8];
                    n_reply[1] = w_prom_word[7:0];
                    n_len      = 2'd2;
                    n_pos      = '0;
                end else if (r_mosi_byte == psm_pkg::CMD_ADC) begin
                    n_reply[0] = w_adc_value[23:16];
                    n_reply[1] = w_adc_value[15:8];
                    n_reply[2] = w_adc_value[7:0];
                    n_len      = 2'd3;
                    n_pos      = '0;
                end else if (r_mosi_byte[7:4] == psm_pkg::CMD_CONV_P ||
                             r_mosi_byte[7:4] == psm_pkg::CMD_CONV_T) begin
                    // Synthetic conversion: offsets follow the counter.
                    n_count           = w_count_inc;
                    n_temp_sel        = (r_mosi_byte[7:4] == psm_pkg::CMD_CONV_T);
                    n_pressure_raw    = i_cfg.pressure_base + {18'd0, w_count_inc};
                    n_temperature_raw = i_cfg.temperature_base +
                                        {18'd0, w_count_inc[4:0], 1'b0};
                end
            end
        end
    end

    // Control state and raw values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_len             <= '0;
            r_pos             <= '0;
            r_pressure_raw    <= psm_pkg::PRESSURE_BASE_RESET;
            r_temperature_raw <= psm_pkg::TEMPERATURE_BASE_RESET;
            r_temp_sel        <= 1'b0;
            r_count           <= '0;
        end else begin
            r_in_valid        <= n_in_valid;
            r_len             <= n_len;
            r_pos             <= n_pos;
            r_pressure_raw    <= n_pressure_raw;
            r_temperature_raw <= n_temperature_raw;
            r_temp_sel        <= n_temp_sel;
            r_count           <= n_count;
        end
    end

    // Payload registers: input beat and reply bytes
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_action    <= i_action;
            r_mosi_byte <= i_mosi_byte;
            r_cs_level  <= i_cs_level;
        end
        r_reply <= n_reply;
    end

endmodule

// ----- rtl/psm_out.sv -----
module psm_out (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_push_data,
    output logic       o_full,
    output logic       o_valid,
    output logic [7:0] o_data,
    input  logic       i_stall
);

    logic [7:0] r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_pop;

    // Two-entry result buffer so that a stalled beat does not hold up the core.
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && !i_stall;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

    // Result storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ----- rtl/pressure_sensor_spi_slave_model.sv -----
// Emulated barometric sensor on an SPI slave link. Each input beat is either
// a byte transfer (one reply byte comes out) or a chip select update (no
// reply). The block takes one beat per clock cycle while its input is not
// stalled: a beat is captured in the input register, is decoded in a single
// pass against the sensor state and lands in a two-entry output buffer, from
// which its reply is offered. Input stalls only when that buffer is full
// behind a stalled output. The PROM CRC nibble is a fixed XOR network
// over the calibration registers, so register writes take effect on the
// next beat.
module pressure_sensor_spi_slave_model (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [7:0]  i_mosi_byte,
    input  logic        i_cs_level,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_miso_byte,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_wr_data
);

    psm_pkg::t_cfg w_cfg;
    logic          w_out_full;
    logic          w_push;
    logic [7:0]    w_push_data;

    // Configuration registers and CRC
    psm_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cfg         (w_cfg)
    );

    // Command decode and sensor state
    psm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_mosi_byte (i_mosi_byte),
        .i_cs_level  (i_cs_level),
        .o_in_stall  (o_in_stall),
        .i_cfg       (w_cfg),
        .i_out_full  (w_out_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // Output buffer
    psm_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_out_full),
        .o_valid     (o_out_valid),
        .o_data      (o_miso_byte),
        .i_stall     (i_out_stall)
    );

endmodule

// ----- rtl/psm_checker.sv -----
`include "pressure_sensor_spi_slave_model_assert.svh"

module psm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_miso_byte
);

    // Reset empties the pipeline and the output buffer.
    `PSM_ASSERT_NEXT_ALWAYS(a_reset_no_out, !i_rst_n, !o_out_valid, "result after reset")
    `PSM_ASSERT_NEXT_ALWAYS(a_reset_no_stall, !i_rst_n, !o_in_stall, "stall after reset")

    // Input only backs up once the output side has been stalled.
    `PSM_ASSERT_NOW(a_stall_cause, o_in_stall, $past(i_out_stall), "stall without output stall")

    // A stalled result beat is held unchanged.
    `PSM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_miso_byte), "stalled result changed")

endmodule

bind pressure_sensor_spi_slave_model psm_checker u_checker (.*);
